/* rtl/traffic_statistics_counters_unit_macros.svh */
// Assertion macros shared by the checker of the traffic statistics unit.
// The macros expect signals named clk and rst_n in the scope that uses them.
`ifndef TRAFFIC_STATISTICS_COUNTERS_UNIT_MACROS_SVH
`define TRAFFIC_STATISTICS_COUNTERS_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tsc_pkg.sv */
// Shared types and constants of the traffic statistics counters unit.
// Used by the sequencer, the RAM wrapper and the top level; no dependencies.
package tsc_pkg;

  // Default sizing of the statistics store.
  localparam int PROCESSES_DEF = 16;
  localparam int SIZE_BINS_DEF = 1501;
  localparam int RATE_BINS_DEF = 1025;
  localparam int BIN_WIDTH_DEF = 32;

  // Rates are binned in units of 1024 bytes per second.
  localparam int RATE_SHIFT = 10;

  // Field widths of the item channels.
  localparam int REQ_W       = 2;
  localparam int PID_W       = 5;
  localparam int DIR_W       = 2;
  localparam int PROTO_W     = 3;
  localparam int SIZE_W      = 16;
  localparam int RATE_W      = 32;
  localparam int SEL_W       = 4;
  localparam int RBIN_W      = 11;
  localparam int VALUE_W     = 64;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 64;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_PACKET = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RATE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Protocol codes at or above this one carry no byte count.
  localparam logic [PROTO_W-1:0] PROTO_UNKNOWN = 3'd4;

  // Read selectors for the histograms; lower codes pick a byte counter.
  localparam logic [SEL_W-1:0] SEL_SIZE_TX = 4'd8;
  localparam logic [SEL_W-1:0] SEL_SIZE_RX = 4'd9;
  localparam logic [SEL_W-1:0] SEL_RATE_TX = 4'd10;
  localparam logic [SEL_W-1:0] SEL_RATE_RX = 4'd11;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [PID_W-1:0]   process_id;
    logic [DIR_W-1:0]   direction;
    logic [PROTO_W-1:0] protocol;
    logic [SIZE_W-1:0]  packet_size;
    logic [RATE_W-1:0]  tx_byte_rate;
    logic [RATE_W-1:0]  rx_byte_rate;
    logic [SEL_W-1:0]   read_counter;
    logic [RBIN_W-1:0]  read_bin;
  } item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

/* rtl/tsc_ram.sv */
// Single-clock RAM with one write and one registered read port.
// Holds the counters of the statistics unit; uses tsc_pkg for the port strobes.
module tsc_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  tsc_pkg::ram_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a waiting result keeps its value.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tsc_ctrl.sv */
// Sequencer of the traffic statistics unit: clearing pass, address generation,
// read-modify-write of both RAMs and the result register. Uses tsc_pkg.
module tsc_ctrl #(
  parameter int PROCESSES = tsc_pkg::PROCESSES_DEF,
  parameter int SIZE_BINS = tsc_pkg::SIZE_BINS_DEF,
  parameter int RATE_BINS = tsc_pkg::RATE_BINS_DEF,
  parameter int BIN_WIDTH = tsc_pkg::BIN_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               item_valid,
  output logic                                               item_ready,
  input  tsc_pkg::item_t                                     item,
  output logic                                               res_valid,
  input  logic                                               res_ready,
  output logic [tsc_pkg::VALUE_W-1:0]                        res_value,
  output logic                                               res_status,
  output tsc_pkg::ram_ctl_t                                  byte_ctl,
  output logic [$clog2((PROCESSES+1)*8)-1:0]                 byte_rd_addr,
  output logic [$clog2((PROCESSES+1)*8)-1:0]                 byte_wr_addr,
  output logic [tsc_pkg::VALUE_W-1:0]                        byte_wr_data,
  input  logic [tsc_pkg::VALUE_W-1:0]                        byte_rd_data,
  output tsc_pkg::ram_ctl_t                                  hist_ctl,
  output logic [$clog2((PROCESSES+1)*2*(SIZE_BINS+RATE_BINS))-1:0] hist_rd_addr,
  output logic [$clog2((PROCESSES+1)*2*(SIZE_BINS+RATE_BINS))-1:0] hist_wr_addr,
  output logic [BIN_WIDTH-1:0]                               hist_wr_data,
  input  logic [BIN_WIDTH-1:0]                               hist_rd_data
);

  localparam int ENTRIES     = PROCESSES + 1;
  localparam int EW          = $clog2(ENTRIES);
  localparam int BYTE_DEPTH  = ENTRIES * 8;
  localparam int BYTE_AW     = $clog2(BYTE_DEPTH);
  localparam int SIZE_REGION = ENTRIES * 2 * SIZE_BINS;
  localparam int HIST_DEPTH  = SIZE_REGION + ENTRIES * 2 * RATE_BINS;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);

  // The size region holds rows (entry*2 + direction) of SIZE_BINS bins, the
  // rate region follows it with rows of RATE_BINS bins.
  localparam logic [HIST_AW-1:0] SIZE_BINS_A   = HIST_AW'(SIZE_BINS);
  localparam logic [HIST_AW-1:0] RATE_BINS_A   = HIST_AW'(RATE_BINS);
  localparam logic [HIST_AW-1:0] SIZE_REGION_A = HIST_AW'(SIZE_REGION);
  localparam logic [HIST_AW-1:0] AGG_SIZE_A    = HIST_AW'(PROCESSES * 2 * SIZE_BINS);
  localparam logic [HIST_AW-1:0] AGG_RATE_A    =
    HIST_AW'(SIZE_REGION + PROCESSES * 2 * RATE_BINS);
  localparam logic [HIST_AW-1:0] HIST_LAST_A   = HIST_AW'(HIST_DEPTH - 1);
  localparam logic [EW-1:0]      AGG_ENTRY     = EW'(PROCESSES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  // Memory operations per item kind.
  localparam logic [2:0] NOPS_NONE   = 3'd0;
  localparam logic [2:0] NOPS_READ   = 3'd1;
  localparam logic [2:0] NOPS_PACKET = 3'd2;
  localparam logic [2:0] NOPS_RATE   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [HIST_AW-1:0]   clr_r, clr_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [2:0]           prev_step;
  tsc_pkg::item_t       item_r;
  logic [2:0]           nops_r, nops_nxt;
  logic                 upd_r, upd_nxt;
  logic                 b_en_r, b_en_nxt;
  logic                 rd_byte_r, rd_byte_nxt;
  logic                 rd_hist_r, rd_hist_nxt;
  logic [HIST_AW-1:0]   h_addr_r [4];
  logic [HIST_AW-1:0]   h_addr_nxt [4];
  logic [BYTE_AW-1:0]   b_addr_r [2];
  logic [BYTE_AW-1:0]   b_addr_nxt [2];
  logic                 out_valid_r;
  logic [tsc_pkg::VALUE_W-1:0] out_value_r;
  logic                 out_status_r;

  // Address generation terms.
  logic [EW-1:0]        pid_e;
  logic                 row_dir;
  logic [EW:0]          row;
  logic                 use_rate;
  logic [HIST_AW-1:0]   bins_c;
  logic [HIST_AW-1:0]   prod;
  logic [HIST_AW-1:0]   sbin;
  logic [HIST_AW-1:0]   tbin;
  logic [HIST_AW-1:0]   rbin;
  logic [HIST_AW-1:0]   rdbin;
  logic                 pid_upd_ok;
  logic                 pid_rd_ok;
  logic                 sel_byte;
  logic                 sel_size;
  logic                 sel_rate;
  logic                 size_bin_ok;
  logic                 rate_bin_ok;
  logic                 res_load;

  assign pid_e      = EW'(item_r.process_id);
  assign pid_upd_ok = 32'(item_r.process_id) < 32'(PROCESSES);
  assign pid_rd_ok  = 32'(item_r.process_id) <= 32'(PROCESSES);
  assign sel_byte   = !item_r.read_counter[tsc_pkg::SEL_W-1];
  assign sel_size   = (item_r.read_counter == tsc_pkg::SEL_SIZE_TX) ||
                      (item_r.read_counter == tsc_pkg::SEL_SIZE_RX);
  assign sel_rate   = (item_r.read_counter == tsc_pkg::SEL_RATE_TX) ||
                      (item_r.read_counter == tsc_pkg::SEL_RATE_RX);
  assign size_bin_ok = 32'(item_r.read_bin) < 32'(SIZE_BINS);
  assign rate_bin_ok = 32'(item_r.read_bin) < 32'(RATE_BINS);

  // One row multiply serves the process entry of every item kind.
  always_comb begin
    use_rate = (item_r.req_type == tsc_pkg::REQ_RATE) ||
               ((item_r.req_type == tsc_pkg::REQ_READ) && sel_rate);
    case (item_r.req_type)
      tsc_pkg::REQ_PACKET: row_dir = item_r.direction[0];
      tsc_pkg::REQ_READ:   row_dir = item_r.read_counter[0];
      default:             row_dir = 1'b0;
    endcase
    row    = {pid_e, row_dir};
    bins_c = use_rate ? RATE_BINS_A : SIZE_BINS_A;
    prod   = HIST_AW'(row) * bins_c;
  end

  // Bin indexes: size clamped to 1..SIZE_BINS, rates in KB/s clamped to the last bin.
  always_comb begin
    if (item_r.packet_size == '0) begin
      sbin = '0;
    end else if (32'(item_r.packet_size) > 32'(SIZE_BINS)) begin
      sbin = HIST_AW'(SIZE_BINS - 1);
    end else begin
      sbin = HIST_AW'(item_r.packet_size - 16'd1);
    end
    if (32'(item_r.tx_byte_rate[tsc_pkg::RATE_W-1:tsc_pkg::RATE_SHIFT]) >
        32'(RATE_BINS - 1)) begin
      tbin = HIST_AW'(RATE_BINS - 1);
    end else begin
      tbin = HIST_AW'(item_r.tx_byte_rate[tsc_pkg::RATE_W-1:tsc_pkg::RATE_SHIFT]);
    end
    if (32'(item_r.rx_byte_rate[tsc_pkg::RATE_W-1:tsc_pkg::RATE_SHIFT]) >
        32'(RATE_BINS - 1)) begin
      rbin = HIST_AW'(RATE_BINS - 1);
    end else begin
      rbin = HIST_AW'(item_r.rx_byte_rate[tsc_pkg::RATE_W-1:tsc_pkg::RATE_SHIFT]);
    end
    rdbin = HIST_AW'(item_r.read_bin);
  end

  // Operation list of the item held in item_r.
  always_comb begin
    nops_nxt    = NOPS_NONE;
    upd_nxt     = 1'b0;
    b_en_nxt    = 1'b0;
    rd_byte_nxt = 1'b0;
    rd_hist_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      h_addr_nxt[i] = '0;
    end
    b_addr_nxt[0] = {pid_e, item_r.direction[0], item_r.protocol[1:0]};
    b_addr_nxt[1] = {AGG_ENTRY, item_r.direction[0], item_r.protocol[1:0]};
    unique case (item_r.req_type)
      tsc_pkg::REQ_PACKET: begin
        if (pid_upd_ok && !item_r.direction[1]) begin
          nops_nxt = NOPS_PACKET;
          upd_nxt  = 1'b1;
          b_en_nxt = item_r.protocol < tsc_pkg::PROTO_UNKNOWN;
        end
        h_addr_nxt[0] = prod + sbin;
        h_addr_nxt[1] = AGG_SIZE_A + (item_r.direction[0] ? SIZE_BINS_A : '0) + sbin;
      end
      tsc_pkg::REQ_RATE: begin
        if (pid_upd_ok) begin
          nops_nxt = NOPS_RATE;
          upd_nxt  = 1'b1;
        end
        h_addr_nxt[0] = SIZE_REGION_A + prod + tbin;
        h_addr_nxt[1] = SIZE_REGION_A + prod + RATE_BINS_A + rbin;
        h_addr_nxt[2] = AGG_RATE_A + tbin;
        h_addr_nxt[3] = AGG_RATE_A + RATE_BINS_A + rbin;
      end
      tsc_pkg::REQ_READ: begin
        nops_nxt      = NOPS_READ;
        rd_byte_nxt   = pid_rd_ok && sel_byte;
        rd_hist_nxt   = pid_rd_ok && ((sel_size && size_bin_ok) ||
                                      (sel_rate && rate_bin_ok));
        b_addr_nxt[0] = {pid_e, item_r.read_counter[2:0]};
        h_addr_nxt[0] = (sel_rate ? SIZE_REGION_A : '0) + prod + rdbin;
      end
      default: begin
        nops_nxt = NOPS_NONE;
      end
    endcase
  end

  assign res_load = (state_r == S_RES) && (!out_valid_r || res_ready);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HIST_LAST_A) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        step_nxt  = '0;
        state_nxt = (nops_nxt == NOPS_NONE) ? S_IDLE : S_RUN;
      end
      S_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == nops_r) begin
          state_nxt = (item_r.req_type == tsc_pkg::REQ_READ) ? S_RES : S_IDLE;
        end
      end
      S_RES: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Step k reads operation k and writes back operation k-1. Operations of one
  // item touch distinct entries, and the next item is not taken before the last
  // write, so no read ever overlaps a pending write of the same entry.
  assign prev_step = step_r - 3'd1;

  always_comb begin
    byte_ctl     = '0;
    hist_ctl     = '0;
    byte_rd_addr = b_addr_r[step_r[0]];
    byte_wr_addr = b_addr_r[prev_step[0]];
    byte_wr_data = byte_rd_data + tsc_pkg::VALUE_W'(item_r.packet_size);
    hist_rd_addr = h_addr_r[step_r[1:0]];
    hist_wr_addr = h_addr_r[prev_step[1:0]];
    hist_wr_data = hist_rd_data + 1'b1;
    if (state_r == S_CLR) begin
      hist_ctl.wr_en = 1'b1;
      hist_wr_addr   = clr_r;
      hist_wr_data   = '0;
      byte_ctl.wr_en = 32'(clr_r) < 32'(BYTE_DEPTH);
      byte_wr_addr   = BYTE_AW'(clr_r);
      byte_wr_data   = '0;
    end else if (state_r == S_RUN) begin
      hist_ctl.rd_en = (step_r < nops_r) && (upd_r || rd_hist_r);
      hist_ctl.wr_en = (step_r != 3'd0) && upd_r;
      byte_ctl.rd_en = (step_r < nops_r) && (rd_byte_r || (upd_r && b_en_r));
      byte_ctl.wr_en = (step_r != 3'd0) && upd_r && b_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      step_r  <= step_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && item_valid) begin
      item_r <= item;
    end
    if (state_r == S_ADDR) begin
      nops_r    <= nops_nxt;
      upd_r     <= upd_nxt;
      b_en_r    <= b_en_nxt;
      rd_byte_r <= rd_byte_nxt;
      rd_hist_r <= rd_hist_nxt;
      h_addr_r  <= h_addr_nxt;
      b_addr_r  <= b_addr_nxt;
    end
    if (res_load) begin
      out_value_r  <= rd_byte_r ? byte_rd_data :
                      rd_hist_r ? tsc_pkg::VALUE_W'(hist_rd_data) : '0;
      out_status_r <= !(rd_byte_r || rd_hist_r);
    end
  end

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = out_valid_r;
  assign res_value  = out_value_r;
  assign res_status = out_status_r;

endmodule

/* rtl/traffic_statistics_counters_unit.sv */
// Traffic statistics counters unit: per-process and aggregate byte counters,
// packet-size and rate histograms. Depends on tsc_pkg, tsc_ram and tsc_ctrl.
//
// Usage: items enter on the in_ stream; in_tuser carries the request kind
// (packet update, rate sample, read). Only read items give a result item on
// the out_ stream, with the counter value in out_tdata and out_tuser set when
// the entry, selector or bin index is out of range (value then zero).
// Each update item is a read-modify-write sequence on two RAMs with a
// registered read: one byte counter RAM and one histogram RAM holding both
// the size and the rate bins. One item is handled at a time: after acceptance
// the sequencer passes an address state, the read and write-back steps of the
// item's RAM operations (two packet updates, four rate updates, one read) and,
// for a read, the result state, before it accepts the next item.
// After reset both RAMs are zeroed by a clearing pass over the
// (PROCESSES+1)*2*(SIZE_BINS+RATE_BINS) histogram addresses, 85884 with the
// defaults, during which in_tready stays low. A result waits in an output
// register while out_tready is low; further updates are still accepted, and
// a new read waits until the register is free.
module traffic_statistics_counters_unit #(
  parameter int PROCESSES = tsc_pkg::PROCESSES_DEF,
  parameter int SIZE_BINS = tsc_pkg::SIZE_BINS_DEF,
  parameter int RATE_BINS = tsc_pkg::RATE_BINS_DEF,
  parameter int BIN_WIDTH = tsc_pkg::BIN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Low bit up: process_id[4:0], direction[6:5], protocol[9:7],
  // packet_size[25:10], tx_byte_rate[57:26], rx_byte_rate[89:58],
  // read_counter[93:90], read_bin[104:94], zero fill[111:105].
  input  logic [tsc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // req_type[1:0].
  input  logic [tsc_pkg::REQ_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_value[63:0].
  output logic [tsc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // read_status.
  output logic                                out_tuser
);

  localparam int ENTRIES    = PROCESSES + 1;
  localparam int BYTE_DEPTH = ENTRIES * 8;
  localparam int HIST_DEPTH = ENTRIES * 2 * (SIZE_BINS + RATE_BINS);
  localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  tsc_pkg::item_t               item;
  tsc_pkg::ram_ctl_t            byte_ctl;
  tsc_pkg::ram_ctl_t            hist_ctl;
  logic [BYTE_AW-1:0]           byte_rd_addr;
  logic [BYTE_AW-1:0]           byte_wr_addr;
  logic [tsc_pkg::VALUE_W-1:0]  byte_wr_data;
  logic [tsc_pkg::VALUE_W-1:0]  byte_rd_data;
  logic [HIST_AW-1:0]           hist_rd_addr;
  logic [HIST_AW-1:0]           hist_wr_addr;
  logic [BIN_WIDTH-1:0]         hist_wr_data;
  logic [BIN_WIDTH-1:0]         hist_rd_data;

  always_comb begin
    item.req_type     = in_tuser;
    item.process_id   = in_tdata[4:0];
    item.direction    = in_tdata[6:5];
    item.protocol     = in_tdata[9:7];
    item.packet_size  = in_tdata[25:10];
    item.tx_byte_rate = in_tdata[57:26];
    item.rx_byte_rate = in_tdata[89:58];
    item.read_counter = in_tdata[93:90];
    item.read_bin     = in_tdata[104:94];
  end

  tsc_ctrl #(
    .PROCESSES (PROCESSES),
    .SIZE_BINS (SIZE_BINS),
    .RATE_BINS (RATE_BINS),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_tvalid),
    .item_ready   (in_tready),
    .item         (item),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_value    (out_tdata),
    .res_status   (out_tuser),
    .byte_ctl     (byte_ctl),
    .byte_rd_addr (byte_rd_addr),
    .byte_wr_addr (byte_wr_addr),
    .byte_wr_data (byte_wr_data),
    .byte_rd_data (byte_rd_data),
    .hist_ctl     (hist_ctl),
    .hist_rd_addr (hist_rd_addr),
    .hist_wr_addr (hist_wr_addr),
    .hist_wr_data (hist_wr_data),
    .hist_rd_data (hist_rd_data)
  );

  tsc_ram #(
    .DEPTH (BYTE_DEPTH),
    .WIDTH (tsc_pkg::VALUE_W)
  ) u_byte_ram (
    .clk     (clk),
    .ctl     (byte_ctl),
    .rd_addr (byte_rd_addr),
    .wr_addr (byte_wr_addr),
    .wr_data (byte_wr_data),
    .rd_data (byte_rd_data)
  );

  tsc_ram #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (BIN_WIDTH)
  ) u_hist_ram (
    .clk     (clk),
    .ctl     (hist_ctl),
    .rd_addr (hist_rd_addr),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_data (hist_rd_data)
  );

endmodule

/* rtl/tsc_checker.sv */
// Port-level checks of the traffic statistics counters unit, bound to the top.
// Uses the assertion macros of traffic_statistics_counters_unit_macros.svh.
`include "traffic_statistics_counters_unit_macros.svh"

module tsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // The clearing pass keeps the unit closed right after reset.
  `TSC_ASSERT_IMP(a_closed_after_reset, $rose(rst_n), !in_tready && !out_tvalid, "unit open after reset")

  // Items are handled one at a time.
  `TSC_ASSERT_NXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "accepted back to back")

  // A result appears only after the unit has been busy with a read.
  `TSC_ASSERT_IMP(a_result_from_work, $rose(out_tvalid), !$past(in_tready), "result while idle")

  // An error result carries a zero value.
  `TSC_ASSERT_IMP(a_error_value_zero, out_tvalid && out_tuser, out_tdata == '0, "error value nonzero")

  // A stalled result holds.
  `TSC_ASSERT_NXT(a_result_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind traffic_statistics_counters_unit tsc_checker u_tsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the traffic statistics counters unit.
// Keeps its own copy of the byte counters and histograms, predicts every read
// item and checks the results in order. Depends on tsc_pkg and the RTL only.
module tb;
  import tsc_pkg::*;

  localparam int PROCESSES   = PROCESSES_DEF;
  localparam int SIZE_BINS   = SIZE_BINS_DEF;
  localparam int RATE_BINS   = RATE_BINS_DEF;
  localparam int BIN_WIDTH   = BIN_WIDTH_DEF;
  localparam int ENTRIES     = PROCESSES + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [REQ_W-1:0]   REQ_NONE    = 2'd3;
  localparam logic [DIR_W-1:0]   DIR_TX      = 2'd0;
  localparam logic [DIR_W-1:0]   DIR_RX      = 2'd1;
  localparam logic [DIR_W-1:0]   DIR_OTHER   = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_TCP   = 3'd0;
  localparam logic [PROTO_W-1:0] PROTO_UDP   = 3'd1;
  localparam logic [PROTO_W-1:0] PROTO_ICMP  = 3'd2;
  localparam logic [PROTO_W-1:0] PROTO_OTHER = 3'd3;
  localparam logic [SEL_W-1:0]   SEL_TOP     = {SEL_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } stats_read_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  // Predicted contents of the statistics store.
  bit [63:0]          model_bytes     [ENTRIES*8];
  bit [BIN_WIDTH-1:0] model_size_bins [ENTRIES*2*SIZE_BINS];
  bit [BIN_WIDTH-1:0] model_rate_bins [ENTRIES*2*RATE_BINS];

  stats_read_t pending_reads[$];
  int mismatch_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rx_hold = 0;

  traffic_statistics_counters_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off while rx_hold counts down.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    stats_read_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result item: read_value %h read_status %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_tdata !== want.value) begin
          $error("read_value: expected %h, actual %h", want.value, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== want.status) begin
          $error("read_status: expected %b, actual %b", want.status, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int rate_bin_of(logic [RATE_W-1:0] rate);
    int b;
    b = rate >> RATE_SHIFT;
    return (b > RATE_BINS - 1) ? RATE_BINS - 1 : b;
  endfunction

  // Applies one accepted item to the predicted store; reads queue their result.
  task automatic count_traffic(input item_t it);
    int pid, dir, sbin, tbin, rbin, sel, hbin;
    stats_read_t r;
    pid = it.process_id;
    dir = it.direction;
    case (it.req_type)
      REQ_PACKET: begin
        if (pid < PROCESSES && dir <= DIR_RX) begin
          if (it.protocol < PROTO_UNKNOWN) begin
            model_bytes[pid*8 + dir*4 + it.protocol] += it.packet_size;
            model_bytes[PROCESSES*8 + dir*4 + it.protocol] += it.packet_size;
          end
          if (it.packet_size == 0) sbin = 0;
          else if (it.packet_size > SIZE_BINS) sbin = SIZE_BINS - 1;
          else sbin = it.packet_size - 1;
          model_size_bins[(pid*2 + dir)*SIZE_BINS + sbin] += 1;
          model_size_bins[(PROCESSES*2 + dir)*SIZE_BINS + sbin] += 1;
        end
      end
      REQ_RATE: begin
        if (pid < PROCESSES) begin
          tbin = rate_bin_of(it.tx_byte_rate);
          rbin = rate_bin_of(it.rx_byte_rate);
          model_rate_bins[(pid*2)*RATE_BINS + tbin] += 1;
          model_rate_bins[(pid*2 + 1)*RATE_BINS + rbin] += 1;
          model_rate_bins[(PROCESSES*2)*RATE_BINS + tbin] += 1;
          model_rate_bins[(PROCESSES*2 + 1)*RATE_BINS + rbin] += 1;
        end
      end
      REQ_READ: begin
        r.value = '0;
        r.status = 1'b1;
        sel = it.read_counter;
        hbin = it.read_bin;
        if (pid <= PROCESSES) begin
          if (sel < SEL_SIZE_TX) begin
            r.value = model_bytes[pid*8 + sel];
            r.status = 1'b0;
          end else if (sel <= SEL_SIZE_RX) begin
            if (hbin < SIZE_BINS) begin
              r.value = model_size_bins[(pid*2 + sel - SEL_SIZE_TX)*SIZE_BINS + hbin];
              r.status = 1'b0;
            end
          end else if (sel <= SEL_RATE_RX) begin
            if (hbin < RATE_BINS) begin
              r.value = model_rate_bins[(pid*2 + sel - SEL_RATE_TX)*RATE_BINS + hbin];
              r.status = 1'b0;
            end
          end
        end
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Valid stays high after a handshake so that a following item can go out
  // in the same cycle; it is lowered only for a gap or while the test waits for results.
  task automatic offer_item(input item_t it);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tdata <= {7'b0, it.read_bin, it.read_counter, it.rx_byte_rate, it.tx_byte_rate,
                 it.packet_size, it.protocol, it.direction, it.process_id};
    in_tuser <= it.req_type;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    count_traffic(it);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    it.req_type     = $urandom;
    it.process_id   = $urandom;
    it.direction    = $urandom;
    it.protocol     = $urandom;
    it.packet_size  = $urandom;
    it.tx_byte_rate = $urandom;
    it.rx_byte_rate = $urandom;
    it.read_counter = $urandom;
    it.read_bin     = $urandom;
    return it;
  endfunction

  function automatic item_t mk_packet(int pid, logic [DIR_W-1:0] dir,
                                      logic [PROTO_W-1:0] proto, int size);
    item_t it;
    it = random_item();
    it.req_type = REQ_PACKET;
    it.process_id = pid;
    it.direction = dir;
    it.protocol = proto;
    it.packet_size = size;
    return it;
  endfunction

  function automatic item_t mk_rate(int pid, logic [RATE_W-1:0] tx, logic [RATE_W-1:0] rx);
    item_t it;
    it = random_item();
    it.req_type = REQ_RATE;
    it.process_id = pid;
    it.tx_byte_rate = tx;
    it.rx_byte_rate = rx;
    return it;
  endfunction

  function automatic item_t mk_read(int pid, logic [SEL_W-1:0] sel, int hbin);
    item_t it;
    it = random_item();
    it.req_type = REQ_READ;
    it.process_id = pid;
    it.read_counter = sel;
    it.read_bin = hbin;
    return it;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(5))
      0, 1, 2: return $urandom_range(40);
      3:       return $urandom;
      4:       return $urandom_range(1495, 1510);
      default: return $urandom_range(41, 1600);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(4))
      0, 1:    return $urandom_range(41*1024 - 1);
      2:       return $urandom;
      3:       return $urandom_range(1015*1024, 1030*1024);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // Bins are drawn near the ones the updates actually hit, plus the range edges.
  function automatic logic [RBIN_W-1:0] pick_bin(logic [SEL_W-1:0] sel);
    if (sel < SEL_SIZE_TX) return $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(40);
      5, 6: begin
        if (sel <= SEL_SIZE_RX) return $urandom_range(1495, 1510);
        return $urandom_range(1015, 1030);
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic on a few busy processes, with some noise.
  function automatic item_t traffic_item();
    item_t it;
    int kind;
    it = random_item();
    kind = $urandom_range(99);
    if (kind < 5) return it;
    it.process_id = $urandom_range(1) ? $urandom_range(3) : $urandom_range(PROCESSES - 1);
    if (kind < 50) begin
      it.req_type = REQ_PACKET;
      it.direction = $urandom_range(DIR_RX);
      if ($urandom_range(9) == 0) it.protocol = $urandom_range(PROTO_UNKNOWN, 7);
      else it.protocol = $urandom_range(PROTO_OTHER);
      it.packet_size = pick_size();
    end else if (kind < 68) begin
      it.req_type = REQ_RATE;
      it.tx_byte_rate = pick_rate();
      it.rx_byte_rate = pick_rate();
    end else begin
      it.req_type = REQ_READ;
      case ($urandom_range(19))
        0:                 it.process_id = $urandom_range(PROCESSES + 1, 2**PID_W - 1);
        1, 2, 3, 4, 5, 6, 7, 8: it.process_id = PROCESSES;
        default: ;
      endcase
      if ($urandom_range(19) == 0) it.read_counter = $urandom_range(SEL_RATE_RX + 1, SEL_TOP);
      else it.read_counter = $urandom_range(SEL_RATE_RX);
      it.read_bin = pick_bin(it.read_counter);
    end
    return it;
  endfunction

  task automatic test_directed_cases();
    item_t odd;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    offer_item(mk_packet(0, DIR_TX, PROTO_TCP, 0));
    offer_item(mk_packet(0, DIR_TX, PROTO_TCP, 1));
    offer_item(mk_packet(0, DIR_RX, PROTO_UDP, SIZE_BINS));
    offer_item(mk_packet(15, DIR_RX, PROTO_OTHER, SIZE_BINS + 1));
    offer_item(mk_packet(15, DIR_TX, PROTO_ICMP, 65535));
    // Unknown protocols still count the packet in its size bin.
    offer_item(mk_packet(3, DIR_TX, PROTO_UNKNOWN, 100));
    offer_item(mk_packet(3, DIR_RX, 3'd7, 200));
    offer_item(mk_packet(3, DIR_OTHER, PROTO_TCP, 300));
    offer_item(mk_packet(3, 2'd3, PROTO_TCP, 300));
    offer_item(mk_packet(PROCESSES, DIR_TX, PROTO_TCP, 400));
    offer_item(mk_rate(0, 32'd0, 32'hFFFF_FFFF));
    offer_item(mk_rate(15, 32'd1023, 32'd1024));
    offer_item(mk_rate(5, 32'd1048575, 32'd1048576));
    offer_item(mk_rate(2**PID_W - 1, 32'd5000, 32'd5000));
    odd = random_item();
    odd.req_type = REQ_NONE;
    offer_item(odd);
    offer_item(mk_read(0, DIR_TX*4 + PROTO_TCP, 0));
    offer_item(mk_read(PROCESSES, DIR_RX*4 + PROTO_UDP, 0));
    offer_item(mk_read(15, DIR_TX*4 + PROTO_ICMP, 0));
    offer_item(mk_read(3, SEL_SIZE_TX, 99));
    offer_item(mk_read(PROCESSES, SEL_SIZE_RX, SIZE_BINS - 1));
    offer_item(mk_read(PROCESSES, SEL_SIZE_TX, SIZE_BINS));
    offer_item(mk_read(PROCESSES, SEL_RATE_TX, RATE_BINS - 1));
    offer_item(mk_read(5, SEL_RATE_RX, RATE_BINS - 1));
    offer_item(mk_read(0, SEL_RATE_RX, RATE_BINS));
    offer_item(mk_read(PROCESSES + 1, 0, 0));
    offer_item(mk_read(2**PID_W - 1, SEL_SIZE_TX, 0));
    offer_item(mk_read(0, SEL_RATE_RX + 1, 0));
    offer_item(mk_read(PROCESSES, SEL_TOP, 2**RBIN_W - 1));
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count, int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (count) offer_item(traffic_item());
    wait_for_results();
  endtask

  // The receiver holds off long enough that a waiting result blocks new reads.
  task automatic test_output_stall();
    item_t it;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rx_hold = 300;
    for (int i = 0; i < 30; i++) begin
      it = traffic_item();
      if (i % 2 == 0) it.req_type = REQ_READ;
      offer_item(it);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(350, 29, 49);
    test_output_stall();
    test_random_traffic(350, 49, 29);
    test_random_traffic(350, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
